### hw/rtl/snx_pkg.sv
// Shared types, constants and helper functions of the 2-D simplex noise block.
package snx_pkg;

    localparam int COORD_FRAC_BITS = 16;
    localparam int TABLE_SIZE_DEF  = 256;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // Skew factors as Q0.32 fractions.
    localparam logic signed [31:0] SKEW_C   = 32'sd1572067139;
    localparam logic signed [31:0] UNSKEW_C = 32'sd907633386;

    localparam int DW    = 24;                      // corner offset width
    localparam int IW    = 34 - COORD_FRAC_BITS;    // lattice index width
    localparam int TW    = COORD_FRAC_BITS - 1;     // attenuation t
    localparam int T2W   = 2 * TW - COORD_FRAC_BITS;
    localparam int T4W   = 2 * T2W - COORD_FRAC_BITS;
    localparam int DOTW  = COORD_FRAC_BITS + 2;
    localparam int CW    = T4W + 1 + DOTW;          // one corner's share
    localparam int SUMW  = CW + 2;
    localparam int SCLW  = SUMW + 6;
    localparam int QW    = 2 * DW + 2;
    localparam int OUTW  = 18;

    localparam int SCALE       = 40;
    localparam int OUT_SHIFT   = 2 * COORD_FRAC_BITS - 16;
    localparam int GSTEP       = 907633386 >> (32 - COORD_FRAC_BITS);
    localparam int MOD12_RECIP = 171;
    localparam int MOD12_SHIFT = 11;
    localparam int GRAD_COUNT  = 12;

    localparam logic signed [DW-1:0] ONE_D = DW'(1 << COORD_FRAC_BITS);
    localparam logic signed [DW-1:0] G1_D  = DW'(GSTEP);
    localparam logic signed [DW-1:0] G2_D  = DW'(2 * GSTEP);
    localparam logic signed [QW-1:0] HALF_Q = QW'(64'sd1 <<< (2 * COORD_FRAC_BITS - 1));
    localparam logic signed [SCLW-1:0] OUT_MAX = SCLW'(131071);
    localparam logic signed [SCLW-1:0] OUT_MIN = -SCLW'(131072);

    typedef struct packed {
        logic valid;
        logic smp;
    } snx_ctl_t;

    // Hash byte reduced to a gradient index 0..11 by reciprocal multiplication.
    function automatic logic [3:0] grad_index(input logic [7:0] v);
        logic [15:0] p;
        logic [4:0]  q;
        logic [7:0]  r;
        p = 16'(v) * 16'(MOD12_RECIP);
        q = p[MOD12_SHIFT +: 5];
        r = v - 8'(q) * 8'(GRAD_COUNT);
        return r[3:0];
    endfunction

    // Dot product of the selected gradient with the corner offset.
    function automatic logic signed [DW:0] grad_dot(input logic [3:0] h,
                                                    input logic signed [DW-1:0] dx,
                                                    input logic signed [DW-1:0] dy);
        logic signed [DW:0] ex;
        logic signed [DW:0] ey;
        logic signed [DW:0] r;
        ex = (DW+1)'(dx);
        ey = (DW+1)'(dy);
        case (h) inside
            4'd0, 4'd8:  r = ex + ey;
            4'd1, 4'd9:  r = ey - ex;
            4'd2, 4'd10: r = ex - ey;
            4'd3, 4'd11: r = -ex - ey;
            4'd4:        r = ex;
            4'd5:        r = -ex;
            4'd6:        r = ey;
            4'd7:        r = -ey;
            default:     r = '0;
        endcase
        return r;
    endfunction

endpackage

### hw/rtl/snx_skew.sv
// Skew pipeline: lattice cell and first corner offset of each sample point.
module snx_skew
    import snx_pkg::*;
#(
    parameter int TABLE_SIZE = TABLE_SIZE_DEF,
    localparam int IDX_W = $clog2(TABLE_SIZE)
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  snx_ctl_t               in_ctl,
    output logic                   in_ready,
    input  logic [IDX_W-1:0]       in_widx,
    input  logic [7:0]             in_wval,
    input  logic signed [31:0]     in_x,
    input  logic signed [31:0]     in_y,
    output snx_ctl_t               out_ctl,
    input  logic                   out_ready,
    output logic [IDX_W-1:0]       out_widx,
    output logic [7:0]             out_wval,
    output logic [IDX_W-1:0]       out_i,
    output logic [IDX_W-1:0]       out_j,
    output logic signed [DW-1:0]   out_x0,
    output logic signed [DW-1:0]   out_y0
);

    localparam int N = 4;

    logic [N:1] v_reg;
    logic [N:1] smp_reg;
    logic [N:1] en;
    logic [IDX_W-1:0] widx_reg [N];
    logic [7:0]       wval_reg [N];

    logic signed [31:0] x1_reg, y1_reg, x2_reg, y2_reg, x3_reg, y3_reg;
    logic signed [32:0] sxy;
    logic signed [64:0] p1_reg;
    logic signed [32:0] s2;
    logic signed [33:0] xs2, ys2;
    logic signed [IW-1:0] i2_reg, j2_reg, i3_reg, j3_reg;
    logic signed [IW:0]   ij3;
    logic signed [IW+32:0] up3_reg;
    logic signed [34:0] u4;
    logic signed [35:0] x0f, y0f;
    logic signed [DW-1:0] x0_reg, y0_reg;
    logic [IDX_W-1:0] i4_reg, j4_reg;

    always_comb
    begin
        en[N] = !v_reg[N] || out_ready;
        for (int k = N - 1; k >= 1; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign in_ready = en[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[1]) v_reg[1] <= in_ctl.valid;
            for (int k = 2; k <= N; k++)
            begin
                if (en[k]) v_reg[k] <= v_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            smp_reg[1]  <= in_ctl.smp;
            widx_reg[0] <= in_widx;
            wval_reg[0] <= in_wval;
        end
        for (int k = 2; k <= N; k++)
        begin
            if (en[k])
            begin
                smp_reg[k]    <= smp_reg[k-1];
                widx_reg[k-1] <= widx_reg[k-2];
                wval_reg[k-1] <= wval_reg[k-2];
            end
        end
    end

    assign sxy = 33'(in_x) + 33'(in_y);
    assign s2  = 33'(p1_reg >>> 32);
    assign xs2 = 34'(x1_reg) + 34'(s2);
    assign ys2 = 34'(y1_reg) + 34'(s2);
    assign ij3 = (IW+1)'(i2_reg) + (IW+1)'(j2_reg);
    assign u4  = 35'(up3_reg >>> (32 - COORD_FRAC_BITS));
    assign x0f = 36'(x3_reg) - (36'(i3_reg) <<< COORD_FRAC_BITS) + 36'(u4);
    assign y0f = 36'(y3_reg) - (36'(j3_reg) <<< COORD_FRAC_BITS) + 36'(u4);

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            x1_reg <= in_x;
            y1_reg <= in_y;
            p1_reg <= 65'(sxy) * 65'(SKEW_C);
        end
        if (en[2])
        begin
            x2_reg <= x1_reg;
            y2_reg <= y1_reg;
            i2_reg <= IW'(xs2 >>> COORD_FRAC_BITS);
            j2_reg <= IW'(ys2 >>> COORD_FRAC_BITS);
        end
        if (en[3])
        begin
            x3_reg  <= x2_reg;
            y3_reg  <= y2_reg;
            i3_reg  <= i2_reg;
            j3_reg  <= j2_reg;
            up3_reg <= (IW+33)'(ij3) * (IW+33)'(UNSKEW_C);
        end
        if (en[4])
        begin
            x0_reg <= x0f[DW-1:0];
            y0_reg <= y0f[DW-1:0];
            i4_reg <= i3_reg[IDX_W-1:0];
            j4_reg <= j3_reg[IDX_W-1:0];
        end
    end

    assign out_ctl.valid = v_reg[N];
    assign out_ctl.smp   = smp_reg[N];
    assign out_widx      = widx_reg[N-1];
    assign out_wval      = wval_reg[N-1];
    assign out_i         = i4_reg;
    assign out_j         = j4_reg;
    assign out_x0        = x0_reg;
    assign out_y0        = y0_reg;

endmodule

### hw/rtl/snx_corner.sv
// Corner setup, permutation table copies with two hash lookups, squared offsets.
module snx_corner
    import snx_pkg::*;
#(
    parameter int TABLE_SIZE = TABLE_SIZE_DEF,
    localparam int IDX_W = $clog2(TABLE_SIZE)
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  snx_ctl_t               in_ctl,
    output logic                   in_ready,
    input  logic [IDX_W-1:0]       in_widx,
    input  logic [7:0]             in_wval,
    input  logic [IDX_W-1:0]       in_i,
    input  logic [IDX_W-1:0]       in_j,
    input  logic signed [DW-1:0]   in_x0,
    input  logic signed [DW-1:0]   in_y0,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [7:0]             out_hash [3],
    output logic signed [2*DW-1:0] out_sqx [3],
    output logic signed [2*DW-1:0] out_sqy [3],
    output logic signed [DW-1:0]   out_dx [3],
    output logic signed [DW-1:0]   out_dy [3]
);

    localparam int N = 3;

    logic [N:1] v_reg;
    logic [N:1] en;
    logic smp1_reg, smp2_reg;
    logic [IDX_W-1:0] widx1_reg, widx2_reg;
    logic [7:0] wval1_reg, wval2_reg, bv_reg;
    logic wr_go;
    logic i1;
    logic [IDX_W-1:0]     ci_c [3];
    logic [IDX_W-1:0]     cj_c [3];
    logic signed [DW-1:0] dx_c [3];
    logic signed [DW-1:0] dy_c [3];

    always_comb
    begin
        en[N] = !v_reg[N] || out_ready;
        for (int k = N - 1; k >= 1; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign in_ready  = en[1];
    assign out_valid = v_reg[N];

    // A table write lands when the write request leaves the second stage.
    assign wr_go = v_reg[2] && (smp2_reg == OP_WRITE) && en[3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[1]) v_reg[1] <= in_ctl.valid;
            if (en[2]) v_reg[2] <= v_reg[1];
            if (en[3]) v_reg[3] <= v_reg[2] && (smp2_reg == OP_SAMPLE);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            smp1_reg  <= in_ctl.smp;
            widx1_reg <= in_widx;
            wval1_reg <= in_wval;
        end
        if (en[2])
        begin
            smp2_reg  <= smp1_reg;
            widx2_reg <= widx1_reg;
            wval2_reg <= wval1_reg;
            bv_reg    <= wval2_reg;
        end
    end

    // The second corner steps along x when x0 exceeds y0, else along y.
    always_comb
    begin
        i1 = in_x0 > in_y0;
        ci_c[0] = in_i;
        cj_c[0] = in_j;
        dx_c[0] = in_x0;
        dy_c[0] = in_y0;
        ci_c[1] = in_i + IDX_W'(i1);
        cj_c[1] = in_j + IDX_W'(!i1);
        dx_c[1] = in_x0 - (i1 ? ONE_D : '0) + G1_D;
        dy_c[1] = in_y0 - (i1 ? '0 : ONE_D) + G1_D;
        ci_c[2] = in_i + IDX_W'(1);
        cj_c[2] = in_j + IDX_W'(1);
        dx_c[2] = in_x0 - ONE_D + G2_D;
        dy_c[2] = in_y0 - ONE_D + G2_D;
    end

    for (genvar k = 0; k < 3; k++)
    begin : g_corner
        logic [7:0] mem [TABLE_SIZE];
        logic [IDX_W-1:0] ci1_reg, cj1_reg, cj2_reg;
        logic signed [DW-1:0] dx1_reg, dy1_reg, dx2_reg, dy2_reg, dx3_reg, dy3_reg;
        logic [7:0] pa_reg, hb_reg, pa_eff;
        logic byp_reg;
        logic [IDX_W-1:0] addr2;
        logic signed [2*DW-1:0] sqx3_reg, sqy3_reg;

        // A write leaving stage two on the same edge as this read is forwarded.
        assign pa_eff = byp_reg ? bv_reg : pa_reg;
        assign addr2  = IDX_W'(pa_eff) + cj2_reg;

        always_ff @(posedge clk)
        begin
            if (wr_go) mem[widx2_reg] <= wval2_reg;
            if (en[2]) pa_reg <= mem[ci1_reg];
            if (en[3]) hb_reg <= mem[addr2];
        end

        always_ff @(posedge clk)
        begin
            if (en[1])
            begin
                ci1_reg <= ci_c[k];
                cj1_reg <= cj_c[k];
                dx1_reg <= dx_c[k];
                dy1_reg <= dy_c[k];
            end
            if (en[2])
            begin
                byp_reg <= wr_go && (widx2_reg == ci1_reg);
                cj2_reg <= cj1_reg;
                dx2_reg <= dx1_reg;
                dy2_reg <= dy1_reg;
            end
            if (en[3])
            begin
                dx3_reg  <= dx2_reg;
                dy3_reg  <= dy2_reg;
                sqx3_reg <= dx2_reg * dx2_reg;
                sqy3_reg <= dy2_reg * dy2_reg;
            end
        end

        assign out_hash[k] = hb_reg;
        assign out_sqx[k]  = sqx3_reg;
        assign out_sqy[k]  = sqy3_reg;
        assign out_dx[k]   = dx3_reg;
        assign out_dy[k]   = dy3_reg;
    end

endmodule

### hw/rtl/snx_shade.sv
// Per-corner attenuation, fourth power and gradient weighting.
module snx_shade
    import snx_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             in_hash [3],
    input  logic signed [2*DW-1:0] in_sqx [3],
    input  logic signed [2*DW-1:0] in_sqy [3],
    input  logic signed [DW-1:0]   in_dx [3],
    input  logic signed [DW-1:0]   in_dy [3],
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic signed [CW-1:0]   out_part [3]
);

    localparam int N = 4;

    logic [N:1] v_reg;
    logic [N:1] en;

    always_comb
    begin
        en[N] = !v_reg[N] || out_ready;
        for (int k = N - 1; k >= 1; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign in_ready  = en[1];
    assign out_valid = v_reg[N];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[1]) v_reg[1] <= in_valid;
            for (int k = 2; k <= N; k++)
            begin
                if (en[k]) v_reg[k] <= v_reg[k-1];
            end
        end
    end

    for (genvar k = 0; k < 3; k++)
    begin : g_corner
        logic signed [QW-1:0] q;
        logic [2*TW-1:0]  tt;
        logic [2*T2W-1:0] t2t2;
        logic signed [DW:0] dot_full;
        logic [TW-1:0]  t1_reg;
        logic [T2W-1:0] t2_reg;
        logic [T4W-1:0] t4_reg;
        logic [3:0] h1_reg;
        logic pos1_reg, pos2_reg, pos3_reg;
        logic signed [DW-1:0] dx1_reg, dy1_reg;
        logic signed [DOTW-1:0] dot2_reg, dot3_reg;
        logic signed [CW-1:0] part_reg;

        assign q        = HALF_Q - QW'(in_sqx[k]) - QW'(in_sqy[k]);
        assign tt       = (2*TW)'(t1_reg) * (2*TW)'(t1_reg);
        assign t2t2     = (2*T2W)'(t2_reg) * (2*T2W)'(t2_reg);
        assign dot_full = grad_dot(h1_reg, dx1_reg, dy1_reg);

        always_ff @(posedge clk)
        begin
            if (en[1])
            begin
                pos1_reg <= q > 0;
                t1_reg   <= q[2*COORD_FRAC_BITS-2:COORD_FRAC_BITS];
                h1_reg   <= grad_index(in_hash[k]);
                dx1_reg  <= in_dx[k];
                dy1_reg  <= in_dy[k];
            end
            if (en[2])
            begin
                pos2_reg <= pos1_reg;
                t2_reg   <= tt[2*TW-1:COORD_FRAC_BITS];
                // Only a positive attenuation keeps the offsets inside this width.
                dot2_reg <= dot_full[DOTW-1:0];
            end
            if (en[3])
            begin
                pos3_reg <= pos2_reg;
                t4_reg   <= t2t2[2*T2W-1:COORD_FRAC_BITS];
                dot3_reg <= dot2_reg;
            end
            if (en[4])
            begin
                part_reg <= pos3_reg ? CW'($signed({1'b0, t4_reg})) * CW'(dot3_reg) : '0;
            end
        end

        assign out_part[k] = part_reg;
    end

endmodule

### hw/rtl/simplex_noise_2d.sv
// Top level of the fixed-point two-dimensional simplex noise block.
//
//  channel | dir | tvalid/tready      | payload
//  --------+-----+--------------------+---------------------------------------------
//  s_*     | in  | s_tvalid/s_tready  | tuser: operation; tdata: index, value, x, y
//  m_*     | out | m_tvalid/m_tready  | tdata: noise_value (Q1.16, saturated)
//
//  A request is taken on every cycle in which s_tvalid and s_tready are both high;
//  the pipeline sustains one request per cycle while m_tready stays high, and a sample
//  passes through four skew, three table and four shading stages, the corner sum
//  and the output register. Two table reads per corner, one after the other, set
//  the depth of the middle section.
//  A table write gives no result; it is applied inside the pipeline in request order.
//  Reset clears only the valid bits; the table contents are undefined until written.
//  Stalls ripple back stage by stage, so empty stages still fill while a result
//  waits, and nothing is dropped or repeated. TABLE_SIZE must be a power of two.
module simplex_noise_2d
    import snx_pkg::*;
#(
    parameter int TABLE_SIZE = TABLE_SIZE_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // table_index[7:0], table_value[15:8],
                                   // coord_x[47:16], coord_y[79:48]
    input  logic [0:0]  s_tuser,   // operation[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // noise_value[17:0], zero above
);

    localparam int IDX_W = $clog2(TABLE_SIZE);

    snx_ctl_t in_ctl, sk_ctl;
    logic sk_ready, cn_valid, cn_ready, sh_valid, sh_ready;
    logic [IDX_W-1:0] sk_widx, sk_i, sk_j;
    logic [7:0] sk_wval;
    logic signed [DW-1:0] sk_x0, sk_y0;
    logic [7:0]             cn_hash [3];
    logic signed [2*DW-1:0] cn_sqx [3];
    logic signed [2*DW-1:0] cn_sqy [3];
    logic signed [DW-1:0]   cn_dx [3];
    logic signed [DW-1:0]   cn_dy [3];
    logic signed [CW-1:0]   sh_part [3];

    logic sum_v_reg, out_v_reg;
    logic en_sum, en_out;
    logic signed [SUMW-1:0] sum_reg;
    logic signed [SCLW-1:0] scaled;
    logic signed [SCLW-1:0] shifted;
    logic signed [OUTW-1:0] noise_next, noise_reg;

    assign in_ctl.valid = s_tvalid;
    assign in_ctl.smp   = s_tuser[0];

    snx_skew #(.TABLE_SIZE(TABLE_SIZE)) u_skew (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ctl    (in_ctl),
        .in_ready  (s_tready),
        .in_widx   (IDX_W'(s_tdata[7:0])),
        .in_wval   (s_tdata[15:8]),
        .in_x      ($signed(s_tdata[47:16])),
        .in_y      ($signed(s_tdata[79:48])),
        .out_ctl   (sk_ctl),
        .out_ready (sk_ready),
        .out_widx  (sk_widx),
        .out_wval  (sk_wval),
        .out_i     (sk_i),
        .out_j     (sk_j),
        .out_x0    (sk_x0),
        .out_y0    (sk_y0)
    );

    snx_corner #(.TABLE_SIZE(TABLE_SIZE)) u_corner (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ctl    (sk_ctl),
        .in_ready  (sk_ready),
        .in_widx   (sk_widx),
        .in_wval   (sk_wval),
        .in_i      (sk_i),
        .in_j      (sk_j),
        .in_x0     (sk_x0),
        .in_y0     (sk_y0),
        .out_valid (cn_valid),
        .out_ready (cn_ready),
        .out_hash  (cn_hash),
        .out_sqx   (cn_sqx),
        .out_sqy   (cn_sqy),
        .out_dx    (cn_dx),
        .out_dy    (cn_dy)
    );

    snx_shade u_shade (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cn_valid),
        .in_ready  (cn_ready),
        .in_hash   (cn_hash),
        .in_sqx    (cn_sqx),
        .in_sqy    (cn_sqy),
        .in_dx     (cn_dx),
        .in_dy     (cn_dy),
        .out_valid (sh_valid),
        .out_ready (sh_ready),
        .out_part  (sh_part)
    );

    // The corner sum and the output register form the last two stages.
    assign en_out   = !out_v_reg || m_tready;
    assign en_sum   = !sum_v_reg || en_out;
    assign sh_ready = en_sum;

    // Scale by forty, drop the extra fraction bits rounding down, then saturate.
    always_comb
    begin
        scaled  = SCLW'(sum_reg) * SCLW'(SCALE);
        shifted = scaled >>> OUT_SHIFT;
        if (shifted > OUT_MAX)
        begin
            noise_next = OUTW'(OUT_MAX);
        end
        else if (shifted < OUT_MIN)
        begin
            noise_next = OUTW'(OUT_MIN);
        end
        else
        begin
            noise_next = OUTW'(shifted);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_v_reg <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (en_sum) sum_v_reg <= sh_valid;
            if (en_out) out_v_reg <= sum_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_sum)
        begin
            sum_reg <= SUMW'(sh_part[0]) + SUMW'(sh_part[1]) + SUMW'(sh_part[2]);
        end
        if (en_out)
        begin
            noise_reg <= noise_next;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {6'b0, noise_reg};

    // The input side only closes when the whole pipeline is backed up.
    a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without a pending result");

    a_sum_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (sum_v_reg && !en_out) |=> (sum_v_reg && $stable(sum_reg)))
        else $error("corner sum changed while stalled");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !sum_v_reg) |=> !m_tvalid)
        else $error("result repeated after it was taken");

endmodule
